// File: src/triangle_modulation_sample_assert.svh
// Assertion macros for the triangle modulation sample block
`ifndef TRIANGLE_MODULATION_SAMPLE_ASSERT_SVH
`define TRIANGLE_MODULATION_SAMPLE_ASSERT_SVH
`ifndef SYNTHESIS
`define TMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("triangle_modulation_sample: assertion failed");
`define TMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle_modulation_sample: assertion failed");
`else
`define TMS_ASSERT(label, prop)
`define TMS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/tms_pkg.sv
package tms_pkg;

  localparam int IDX_W      = 16;
  localparam int AMP_W      = 17;
  localparam int SAMPLE_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int NUM_W      = 2 * AMP_W + 2;
  localparam int CNT_W      = 5;
  localparam int GK_W       = 4;

  localparam int DIV_STEPS = IDX_W;
  localparam int MUL_STEPS = IDX_W;
  localparam int MAC_STEPS = AMP_W;
  localparam int QUO_STEPS = SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_FREQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd4;

  localparam logic [IDX_W-1:0] RATE_RST = 16'd4000;
  localparam logic [IDX_W-1:0] BUF_RST  = 16'd4000;
  localparam logic [IDX_W-1:0] FREQ_RST = 16'd150;
  localparam logic [AMP_W-1:0] AMP_RST  = 17'd65536;
  localparam logic [AMP_W-1:0] OFF_RST  = 17'd32768;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

endpackage

// File: src/triangle_modulation_sample.sv
// Triangle modulation sample generator.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 sample
// rate, 1 buffer size, 2 wave frequency, 3 amplitude, 4 offset) at the clock
// edge; write only while busy is low and no result is pending.
// Request: a transfer happens at a clock edge with start high and busy low;
// sample_index_i is taken. busy stays high until the result (usable config).
// Result: valid_o is high for exactly one cycle with sample_o, table_length_o,
// last_o, out_of_range_o and config_error_o; the receiver cannot stall it.
// Sequence: an unusable configuration leaves busy low and its result follows
// in the next cycle. Otherwise a binary gcd loop, four runs of one restoring
// divider, then for an in-range index a modular multiply, a fold step, a
// shift-add accumulate, a check step, a quotient and a final step; the
// quotient and final step are skipped when the level sits at either limit.
// An out-of-range index ends after the divider.
// One request is in flight at a time; the next start may come in the cycle
// the result strobe is high.
// Reset: registers return to 4000, 4000, 150, 1.0, 0.5; no result is pending.
`include "triangle_modulation_sample_assert.svh"

module triangle_modulation_sample import tms_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      sample_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  valid_o,
  output logic [SAMPLE_W-1:0]   sample_o,
  output logic [IDX_W-1:0]      table_length_o,
  output logic                  last_o,
  output logic                  out_of_range_o,
  output logic                  config_error_o
);

  localparam int DEN_W = AMP_W + FRACTION_BITS;
  localparam int REM_W = (NUM_W + 1 > DEN_W + 2) ? NUM_W + 1 : DEN_W + 2;
  localparam int S_W   = IDX_W + 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCD  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_FOLD = 4'd4;
  localparam logic [3:0] S_MAC  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_QUO  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [1:0] OP_PER  = 2'd0;
  localparam logic [1:0] OP_BUFD = 2'd1;
  localparam logic [1:0] OP_LEN  = 2'd2;
  localparam logic [1:0] OP_REP  = 2'd3;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(MAC_STEPS - 1);
  localparam logic [CNT_W-1:0] QUO_LAST = CNT_W'(QUO_STEPS - 1);

  logic [IDX_W-1:0] rate_q, buf_q, wave_q;
  logic [AMP_W-1:0] amp_q, off_q;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d, freq_q, freq_d;
  logic [IDX_W-1:0] ga_q, ga_d, gb_q, gb_d;
  logic [GK_W-1:0]  gk_q, gk_d;
  logic [IDX_W-1:0] d_q, d_d, per_q, per_d, n_q, n_d, rep_q, rep_d;
  logic [IDX_W-1:0] dq_q, dq_d, dr_q, dr_d, dd_q, dd_d;
  logic [IDX_W:0]   t_q, t_d;
  logic             is_last_q, is_last_d;
  logic signed [S_W-1:0]   s_q, s_d, ts_q, ts_d;
  logic signed [NUM_W-1:0] acc_q, acc_d;
  logic [AMP_W-1:0] am_q, am_d, of_q, of_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [SAMPLE_W-1:0] qb_q, qb_d;

  logic                valid_q, valid_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [IDX_W-1:0]    tlen_q, tlen_d;
  logic                last_q, last_d, oor_q, oor_d, cerr_q, cerr_d;

  logic [IDX_W-1:0] half_rate, freq_c;
  logic             cfg_bad;
  logic [1:0]       ld_op;
  logic [IDX_W-1:0] ld_dvd, ld_dvs;
  logic [IDX_W:0]   div_trial, div_sub;
  logic             div_ge;
  logic [IDX_W-1:0] div_rem, div_quo;
  logic [IDX_W:0]   twon, rep2;
  logic [IDX_W+1:0] mul_dbl, mul_sum, twon_x;
  logic [IDX_W:0]   mul_m1, mul_m2, fold_t;
  logic signed [S_W-1:0]   fold_s;
  logic signed [NUM_W-1:0] mac_add;
  logic [REM_W-1:0] den_w, num_w, quo_dbl, quo_sub;
  logic             num_pos, num_ge, quo_ge;

  assign half_rate = rate_q >> 1;
  assign freq_c    = (wave_q == '0) ? IDX_W'(1) : ((wave_q > half_rate) ? half_rate : wave_q);
  assign cfg_bad   = (rate_q < IDX_W'(2)) || (buf_q < rate_q);

  assign ld_op = (state_q == S_GCD) ? OP_PER : op_q + 2'd1;

  always_comb begin
    case (ld_op)
      OP_PER: begin
        ld_dvd = buf_q;
        ld_dvs = rate_q;
      end
      OP_BUFD: begin
        ld_dvd = buf_q;
        ld_dvs = d_q;
      end
      OP_LEN: begin
        ld_dvd = div_quo;
        ld_dvs = per_q;
      end
      default: begin
        ld_dvd = freq_q;
        ld_dvs = d_q;
      end
    endcase
  end

  assign div_trial = {dr_q, dq_q[IDX_W-1]};
  assign div_ge    = div_trial >= {1'b0, dd_q};
  assign div_sub   = div_trial - {1'b0, dd_q};
  assign div_rem   = div_ge ? div_sub[IDX_W-1:0] : div_trial[IDX_W-1:0];
  assign div_quo   = {dq_q[IDX_W-2:0], div_ge};

  assign twon    = {n_q, 1'b0};
  assign rep2    = {rep_q, 1'b0};
  assign twon_x  = {1'b0, twon};
  assign mul_dbl = {t_q, 1'b0};
  assign mul_m1  = (mul_dbl >= twon_x) ? (mul_dbl[IDX_W:0] - twon) : mul_dbl[IDX_W:0];
  assign mul_sum = {1'b0, mul_m1} + {1'b0, rep2};
  assign mul_m2  = (mul_sum >= twon_x) ? (mul_sum[IDX_W:0] - twon) : mul_sum[IDX_W:0];

  assign fold_t = (t_q > {1'b0, n_q}) ? (twon - t_q) : t_q;
  assign fold_s = $signed({1'b0, fold_t, 1'b0}) - $signed({3'b000, n_q});

  always_comb begin
    case ({of_q[AMP_W-1], am_q[AMP_W-1]})
      2'b10:   mac_add = $signed({{(NUM_W-IDX_W-1){1'b0}}, twon});
      2'b01:   mac_add = {{(NUM_W-S_W){s_q[S_W-1]}}, s_q};
      2'b11:   mac_add = {{(NUM_W-S_W){ts_q[S_W-1]}}, ts_q};
      default: mac_add = '0;
    endcase
  end

  assign den_w   = {{(REM_W-DEN_W){1'b0}}, twon, {FRACTION_BITS{1'b0}}};
  assign num_w   = {{(REM_W-NUM_W){acc_q[NUM_W-1]}}, acc_q};
  assign num_pos = !acc_q[NUM_W-1] && (acc_q != '0);
  assign num_ge  = num_w >= den_w;
  assign quo_dbl = {rem_q[REM_W-2:0], 1'b0};
  assign quo_ge  = quo_dbl >= den_w;
  assign quo_sub = quo_dbl - den_w;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    idx_d     = idx_q;
    freq_d    = freq_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    gk_d      = gk_q;
    d_d       = d_q;
    per_d     = per_q;
    n_d       = n_q;
    rep_d     = rep_q;
    dq_d      = dq_q;
    dr_d      = dr_q;
    dd_d      = dd_q;
    t_d       = t_q;
    is_last_d = is_last_q;
    s_d       = s_q;
    ts_d      = ts_q;
    acc_d     = acc_q;
    am_d      = am_q;
    of_d      = of_q;
    rem_d     = rem_q;
    qb_d      = qb_q;
    valid_d   = 1'b0;
    sample_d  = sample_q;
    tlen_d    = tlen_q;
    last_d    = last_q;
    oor_d     = oor_q;
    cerr_d    = cerr_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          idx_d = sample_index_i;
          if (cfg_bad) begin
            valid_d  = 1'b1;
            sample_d = '0;
            tlen_d   = '0;
            last_d   = 1'b0;
            oor_d    = 1'b1;
            cerr_d   = 1'b1;
          end else begin
            freq_d  = freq_c;
            ga_d    = rate_q;
            gb_d    = freq_c;
            gk_d    = '0;
            state_d = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (ga_q == gb_q) begin
          d_d     = ga_q << gk_q;
          op_d    = OP_PER;
          dq_d    = ld_dvd;
          dd_d    = ld_dvs;
          dr_d    = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          gk_d = gk_q + GK_W'(1);
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (ga_q > gb_q) begin
          ga_d = (ga_q - gb_q) >> 1;
        end else begin
          gb_d = (gb_q - ga_q) >> 1;
        end
      end
      S_DIV: begin
        dq_d  = div_quo;
        dr_d  = div_rem;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          case (op_q)
            OP_PER:  per_d = div_quo;
            OP_BUFD: n_d = div_quo;
            OP_LEN:  n_d = div_quo;
            default: rep_d = div_quo;
          endcase
          if (op_q != OP_REP) begin
            op_d  = op_q + 2'd1;
            dq_d  = ld_dvd;
            dd_d  = ld_dvs;
            dr_d  = '0;
            cnt_d = '0;
          end else if ((n_q == '0) || (idx_q >= n_q)) begin
            valid_d  = 1'b1;
            sample_d = '0;
            tlen_d   = n_q;
            last_d   = 1'b0;
            oor_d    = 1'b1;
            cerr_d   = 1'b0;
            state_d  = S_IDLE;
          end else begin
            is_last_d = ({1'b0, idx_q} + (IDX_W+1)'(1)) == {1'b0, n_q};
            t_d       = '0;
            cnt_d     = '0;
            state_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        t_d   = idx_q[IDX_W-1] ? mul_m2 : mul_m1;
        idx_d = idx_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        s_d     = fold_s;
        ts_d    = fold_s + $signed({2'b00, twon});
        acc_d   = '0;
        am_d    = amp_q;
        of_d    = off_q;
        cnt_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        acc_d = (acc_q <<< 1) + mac_add;
        am_d  = am_q << 1;
        of_d  = of_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MAC_LAST) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!num_pos || num_ge) begin
          valid_d  = 1'b1;
          sample_d = num_pos ? SAMPLE_MAX : '0;
          tlen_d   = n_q;
          last_d   = is_last_q;
          oor_d    = 1'b0;
          cerr_d   = 1'b0;
          state_d  = S_IDLE;
        end else begin
          rem_d   = num_w;
          qb_d    = '0;
          cnt_d   = '0;
          state_d = S_QUO;
        end
      end
      S_QUO: begin
        rem_d = quo_ge ? quo_sub : quo_dbl;
        qb_d  = {qb_q[SAMPLE_W-2:0], quo_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == QUO_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        valid_d  = 1'b1;
        sample_d = qb_q - {{(SAMPLE_W-1){1'b0}}, (rem_q < num_w)};
        tlen_d   = n_q;
        last_d   = is_last_q;
        oor_d    = 1'b0;
        cerr_d   = 1'b0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      rate_q  <= RATE_RST;
      buf_q   <= BUF_RST;
      wave_q  <= FREQ_RST;
      amp_q   <= AMP_RST;
      off_q   <= OFF_RST;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAMPLE_RATE: rate_q <= cfg_data_i[IDX_W-1:0];
          REG_BUFFER_SIZE: buf_q  <= cfg_data_i[IDX_W-1:0];
          REG_WAVE_FREQ:   wave_q <= cfg_data_i[IDX_W-1:0];
          REG_AMPLITUDE:   amp_q  <= cfg_data_i[AMP_W-1:0];
          REG_OFFSET:      off_q  <= cfg_data_i[AMP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    op_q      <= op_d;
    idx_q     <= idx_d;
    freq_q    <= freq_d;
    ga_q      <= ga_d;
    gb_q      <= gb_d;
    gk_q      <= gk_d;
    d_q       <= d_d;
    per_q     <= per_d;
    n_q       <= n_d;
    rep_q     <= rep_d;
    dq_q      <= dq_d;
    dr_q      <= dr_d;
    dd_q      <= dd_d;
    t_q       <= t_d;
    is_last_q <= is_last_d;
    s_q       <= s_d;
    ts_q      <= ts_d;
    acc_q     <= acc_d;
    am_q      <= am_d;
    of_q      <= of_d;
    rem_q     <= rem_d;
    qb_q      <= qb_d;
    sample_q  <= sample_d;
    tlen_q    <= tlen_d;
    last_q    <= last_d;
    oor_q     <= oor_d;
    cerr_q    <= cerr_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign sample_o       = sample_q;
  assign table_length_o = tlen_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;
  assign config_error_o = cerr_q;

  `TMS_ASSERT(a_result_ends_busy, valid_q |-> !busy)
  `TMS_ASSERT_NEXT(a_cfg_error_at_once, (state_q == S_IDLE) && start && cfg_bad, valid_q && cerr_q)
  `TMS_ASSERT(a_error_fields, (valid_q && cerr_q) |-> ((tlen_q == '0) && oor_q))
  `TMS_ASSERT(a_oor_fields, (valid_q && oor_q) |-> ((sample_q == '0) && !last_q))
  `TMS_ASSERT(a_gcd_nonzero, (state_q == S_GCD) |-> ((ga_q != '0) && (gb_q != '0)))
  `TMS_ASSERT(a_quo_rem_bound, (state_q == S_QUO) |-> (rem_q < den_w))

endmodule
